### hw/rtl/bsfc_pkg.sv
// Shared types and constants of the balancing state-feedback controller.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bsfc_pkg;

  localparam int DATA_W      = 32;
  localparam int REF_SPEED_W = 18;
  localparam int REF_TURN_W  = 20;
  localparam int CFG_IDX_W   = 3;

  // The serial dividers see a 35-bit signed numerator; the quotient is one bit narrower.
  localparam int NUM_W = 35;
  localparam int QUO_W = NUM_W - 1;

  localparam int POS_DIVISOR = 20;
  localparam int YAW_DIVISOR = 250;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE      = 3'd0,
    CFG_SPEED_MODE  = 3'd1,
    CFG_RATE_MODE   = 3'd2,
    CFG_REF_DISP    = 3'd3,
    CFG_REF_SPEED   = 3'd4,
    CFG_REF_HEADING = 3'd5,
    CFG_REF_TURN    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_wheel_angle;
    logic signed [DATA_W-1:0] right_wheel_angle;
    logic signed [DATA_W-1:0] yaw_rate;
    logic signed [DATA_W-1:0] pitch_angle;
    logic signed [DATA_W-1:0] pitch_rate;
    logic                     latch_offset;
    logic                     clear_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_torque;
    logic signed [DATA_W-1:0] right_torque;
  } out_item_t;

endpackage

### hw/rtl/bsfc_if.sv
// Valid/ready channel interfaces for sensor requests and torque results.
// Depends on bsfc_pkg for the payload types.
`timescale 1ns / 1ps

interface bsfc_in_if;
  import bsfc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bsfc_out_if;
  import bsfc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/bsfc_const_div.sv
// Bit-serial restoring divider by a constant, rounding toward minus infinity.
// Depends on bsfc_pkg for default widths; one quotient bit per cycle.
`timescale 1ns / 1ps

module bsfc_const_div #(
  parameter int NumW    = bsfc_pkg::NUM_W,
  parameter int Divisor = bsfc_pkg::POS_DIVISOR
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  output logic                   busy_o,
  output logic signed [NumW-2:0] quo_o
);
  import bsfc_pkg::*;

  localparam int QuoW = NumW - 1;
  localparam int RemW = $clog2(2 * Divisor);
  localparam int CntW = $clog2(QuoW);
  localparam logic [CntW-1:0] LastStep = CntW'(QuoW - 1);
  localparam logic [RemW-1:0] DivisorV = RemW'(Divisor);

  logic [QuoW-1:0] mag_q;
  logic [RemW-2:0] rem_q;
  logic            neg_q;
  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [RemW-1:0] trial;
  logic            fits;
  logic [RemW-1:0] rem_d;

  assign trial = {rem_q, mag_q[QuoW-1]};
  assign fits  = (trial >= DivisorV);
  assign rem_d = fits ? (trial - DivisorV) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  // A negative numerator v is divided as ~v, and the quotient is complemented:
  // floor(v / d) equals ~floor(~v / d) for v below zero.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NumW-1];
      mag_q <= num_i[NumW-1] ? ~num_i[QuoW-1:0] : num_i[QuoW-1:0];
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[QuoW-2:0], fits};
      rem_q <= rem_d[RemW-2:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? ~mag_q : mag_q;

endmodule

### hw/rtl/balancing_state_feedback_controller_core.sv
// Top level of the balancing state-feedback controller: config registers, sequencer,
// bit-serial state update and gain accumulation. Depends on bsfc_pkg, bsfc_if, bsfc_const_div.
//
//   Channel   Dir  Carries                                   Handshake
//   req_i     in   wheel angles, yaw, pitch, flags           valid/ready, taken when both high
//   rsp_o     out  left and right torque                     valid/ready, taken when both high
//   cfg_*     in   register index and write data             write enable, no back-pressure
//
// A request passes through the two serial dividers that form the position and the heading
// increment, a load step, the LSB-first serial accumulation of both torques, a saturation
// step into the output register and the idle step that accepts the next request.
// Reset clears the configuration to its defaults and the position and heading state.
// A new request is taken while a finished result still waits in the output register;
// the sequencer only holds in its last step while that register is full.
`timescale 1ns / 1ps

module balancing_state_feedback_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsfc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bsfc_pkg::DATA_W-1:0]    cfg_wdata_i,
  bsfc_in_if.sink                        req_i,
  bsfc_out_if.source                     rsp_o
);
  import bsfc_pkg::*;

  localparam int ACC_W = 44;
  localparam int SUM_W = 13;
  localparam int CNT_W = $clog2(ACC_W);
  localparam logic [CNT_W-1:0] LAST_BIT   = CNT_W'(ACC_W - 1);
  localparam logic [CNT_W-1:0] STATE_BITS = CNT_W'(DATA_W);

  localparam int YAW_SHIFT = 2;
  localparam int G_X       = 10;
  localparam int SPEED_NUM = 125;

  localparam logic signed [SUM_W-1:0] W_X      = SUM_W'(G_X);
  localparam logic signed [SUM_W-1:0] W_SPEED  = SUM_W'(G_X * SPEED_NUM / 2);
  localparam logic signed [SUM_W-1:0] W_PARITY = SUM_W'(G_X / 2);
  localparam logic signed [SUM_W-1:0] W_HEAD   = SUM_W'(12);
  localparam logic signed [SUM_W-1:0] W_TURN   = SUM_W'(1);
  localparam logic signed [SUM_W-1:0] W_PITCH  = SUM_W'(80);

  localparam logic signed [REF_SPEED_W-1:0] SPEED_MAX = REF_SPEED_W'(65536);
  localparam logic signed [REF_SPEED_W-1:0] SPEED_MIN = -SPEED_MAX;
  localparam logic signed [REF_TURN_W-1:0]  TURN_MAX  = REF_TURN_W'(327680);
  localparam logic signed [REF_TURN_W-1:0]  TURN_MIN  = -TURN_MAX;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StSer,
    StOut
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             rsp_valid_q;
  out_item_t        rsp_data_q;

  // Configuration registers.
  logic                           en_q;
  logic                           speed_mode_q;
  logic                           rate_mode_q;
  logic signed [DATA_W-1:0]       ref_disp_q;
  logic signed [REF_SPEED_W-1:0]  ref_speed_q;
  logic signed [DATA_W-1:0]       ref_heading_q;
  logic signed [REF_TURN_W-1:0]   ref_turn_q;

  // Controller state.
  logic [DATA_W-1:0] prev_q;
  logic [DATA_W-1:0] offset_q;
  logic [DATA_W-1:0] heading_q;

  // Operand shift registers, shifted right with sign fill.
  logic signed [DATA_W-1:0]      disp_sr_q;
  logic signed [REF_SPEED_W-1:0] speed_sr_q;
  logic signed [DATA_W-1:0]      head_sr_q;
  logic signed [REF_TURN_W-1:0]  turn_sr_q;
  logic signed [DATA_W-1:0]      yaw_sr_q;
  logic signed [DATA_W-1:0]      pitch_sr_q;
  logic signed [DATA_W-1:0]      prate_sr_q;
  logic signed [QUO_W-1:0]       pos_sr_q;
  logic signed [QUO_W-1:0]       qy_sr_q;
  logic [ACC_W-1:0]              acc_l_q;
  logic [ACC_W-1:0]              acc_r_q;
  logic signed [SUM_W-1:0]       carry_l_q;
  logic signed [SUM_W-1:0]       carry_r_q;
  logic                          hcarry_q;
  logic                          d0_q;
  logic                          vsign_q;

  in_item_t                      item;
  logic                          req_fire;
  logic signed [NUM_W-1:0]       pos_num;
  logic signed [NUM_W-1:0]       yaw_num;
  logic                          pos_busy;
  logic                          yaw_busy;
  logic                          div_busy;
  logic signed [QUO_W-1:0]       pos_quo;
  logic signed [QUO_W-1:0]       yaw_quo;
  logic signed [REF_SPEED_W-1:0] speed_lim;
  logic signed [REF_TURN_W-1:0]  turn_lim;

  logic                          ser_low;
  logic                          p_bit;
  logic                          q_bit;
  logic                          v_bit;
  logic                          o_bit;
  logic                          h_bit;
  logic                          h_sum;
  logic                          h_cout;
  logic signed [SUM_W-1:0]       common;
  logic signed [SUM_W-1:0]       diff;
  logic signed [SUM_W-1:0]       t_l;
  logic signed [SUM_W-1:0]       t_r;
  out_item_t                     result;

  function automatic logic signed [SUM_W-1:0] wt(logic b, logic signed [SUM_W-1:0] c);
    return b ? c : '0;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat(logic [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] hi;
    hi = v[ACC_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  assign item        = req_i.payload;
  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;

  assign pos_num = NUM_W'(item.left_wheel_angle) + NUM_W'(item.right_wheel_angle) +
                   NUM_W'(POS_DIVISOR / 2);
  assign yaw_num = (NUM_W'(item.yaw_rate) <<< YAW_SHIFT) + NUM_W'(YAW_DIVISOR / 2);

  bsfc_const_div #(
    .NumW    (NUM_W),
    .Divisor (POS_DIVISOR)
  ) u_pos_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (req_fire),
    .num_i   (pos_num),
    .busy_o  (pos_busy),
    .quo_o   (pos_quo)
  );

  bsfc_const_div #(
    .NumW    (NUM_W),
    .Divisor (YAW_DIVISOR)
  ) u_yaw_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (req_fire),
    .num_i   (yaw_num),
    .busy_o  (yaw_busy),
    .quo_o   (yaw_quo)
  );

  assign div_busy = pos_busy | yaw_busy;

  always_comb begin
    if (ref_speed_q > SPEED_MAX) begin
      speed_lim = SPEED_MAX;
    end else if (ref_speed_q < SPEED_MIN) begin
      speed_lim = SPEED_MIN;
    end else begin
      speed_lim = ref_speed_q;
    end
    if (ref_turn_q > TURN_MAX) begin
      turn_lim = TURN_MAX;
    end else if (ref_turn_q < TURN_MIN) begin
      turn_lim = TURN_MIN;
    end else begin
      turn_lim = ref_turn_q;
    end
  end

  // The 32-bit state words are only updated during the low 32 serial steps; above that
  // each stream repeats its sign bit.
  assign ser_low = (cnt_q < STATE_BITS);
  assign p_bit   = pos_sr_q[0];
  assign q_bit   = qy_sr_q[0];
  assign h_sum   = heading_q[0] ^ q_bit ^ hcarry_q;
  assign h_cout  = (heading_q[0] & q_bit) | (hcarry_q & (heading_q[0] ^ q_bit));
  assign h_bit   = ser_low ? h_sum : heading_q[DATA_W-1];
  assign v_bit   = ser_low ? prev_q[0] : vsign_q;
  assign o_bit   = ser_low ? offset_q[0] : offset_q[DATA_W-1];

  // Each torque is a sum of small constants times operand bits plus a signed carry.
  // The speed term uses 10*speed = 5*(125*(pos - prev) + parity of the difference).
  always_comb begin
    common = wt(p_bit, W_SPEED) - wt(v_bit, W_SPEED)
           - wt(disp_sr_q[0], W_X) - wt(speed_sr_q[0], W_X)
           + wt(pitch_sr_q[0], W_PITCH) + wt(prate_sr_q[0], W_X);
    if (!speed_mode_q) begin
      common = common + wt(p_bit, W_X) - wt(o_bit, W_X);
    end
    if (cnt_q == '0) begin
      common = common + wt(d0_q, W_PARITY);
    end
    diff = wt(head_sr_q[0], W_HEAD) + wt(turn_sr_q[0], W_TURN) - wt(yaw_sr_q[0], W_TURN);
    if (!rate_mode_q) begin
      diff = diff - wt(h_bit, W_HEAD);
    end
    t_l = carry_l_q + common + diff;
    t_r = carry_r_q + common - diff;
  end

  always_comb begin
    result.left_torque  = en_q ? sat(acc_l_q) : '0;
    result.right_torque = en_q ? sat(acc_r_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q          <= 1'b1;
      speed_mode_q  <= 1'b1;
      rate_mode_q   <= 1'b1;
      ref_disp_q    <= '0;
      ref_speed_q   <= '0;
      ref_heading_q <= '0;
      ref_turn_q    <= '0;
      prev_q        <= '0;
      offset_q      <= '0;
      heading_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ENABLE:      en_q          <= cfg_wdata_i[0];
          CFG_SPEED_MODE:  speed_mode_q  <= cfg_wdata_i[0];
          CFG_RATE_MODE:   rate_mode_q   <= cfg_wdata_i[0];
          CFG_REF_DISP:    ref_disp_q    <= cfg_wdata_i;
          CFG_REF_SPEED:   ref_speed_q   <= cfg_wdata_i[REF_SPEED_W-1:0];
          CFG_REF_HEADING: ref_heading_q <= cfg_wdata_i;
          CFG_REF_TURN:    ref_turn_q    <= cfg_wdata_i[REF_TURN_W-1:0];
          default: ;
        endcase
      end
      if (req_fire) begin
        if (item.latch_offset) begin
          offset_q <= prev_q;
        end
        if (item.clear_heading) begin
          heading_q <= '0;
        end
      end else if (state_q == StSer && ser_low) begin
        // The previous position fills with the new one, the offset rotates back to
        // itself, and the heading takes the serial sum with its increment.
        prev_q    <= {p_bit, prev_q[DATA_W-1:1]};
        offset_q  <= {offset_q[0], offset_q[DATA_W-1:1]};
        heading_q <= {h_sum, heading_q[DATA_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      disp_sr_q  <= ref_disp_q;
      speed_sr_q <= speed_lim;
      head_sr_q  <= ref_heading_q;
      turn_sr_q  <= turn_lim;
      yaw_sr_q   <= item.yaw_rate;
      pitch_sr_q <= item.pitch_angle;
      prate_sr_q <= item.pitch_rate;
    end else if (state_q == StDiv && !div_busy) begin
      pos_sr_q  <= pos_quo;
      qy_sr_q   <= yaw_quo;
      d0_q      <= pos_quo[0] ^ prev_q[0];
      vsign_q   <= prev_q[DATA_W-1];
      hcarry_q  <= 1'b0;
      carry_l_q <= '0;
      carry_r_q <= '0;
    end else if (state_q == StSer) begin
      disp_sr_q  <= {disp_sr_q[DATA_W-1], disp_sr_q[DATA_W-1:1]};
      speed_sr_q <= {speed_sr_q[REF_SPEED_W-1], speed_sr_q[REF_SPEED_W-1:1]};
      head_sr_q  <= {head_sr_q[DATA_W-1], head_sr_q[DATA_W-1:1]};
      turn_sr_q  <= {turn_sr_q[REF_TURN_W-1], turn_sr_q[REF_TURN_W-1:1]};
      yaw_sr_q   <= {yaw_sr_q[DATA_W-1], yaw_sr_q[DATA_W-1:1]};
      pitch_sr_q <= {pitch_sr_q[DATA_W-1], pitch_sr_q[DATA_W-1:1]};
      prate_sr_q <= {prate_sr_q[DATA_W-1], prate_sr_q[DATA_W-1:1]};
      pos_sr_q   <= {pos_sr_q[QUO_W-1], pos_sr_q[QUO_W-1:1]};
      qy_sr_q    <= {qy_sr_q[QUO_W-1], qy_sr_q[QUO_W-1:1]};
      acc_l_q    <= {t_l[0], acc_l_q[ACC_W-1:1]};
      acc_r_q    <= {t_r[0], acc_r_q[ACC_W-1:1]};
      carry_l_q  <= t_l >>> 1;
      carry_r_q  <= t_r >>> 1;
      hcarry_q   <= h_cout;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_data_q  <= '0;
    end else begin
      // In the output step the register is either refilled or held full.
      if (rsp_valid_q && rsp_o.ready && state_q != StOut) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (req_fire) begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (!div_busy) begin
            state_q <= StSer;
            cnt_q   <= '0;
          end
        end
        StSer: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_BIT) begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            rsp_data_q  <= result;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_data_q;

endmodule

### bench/tb.sv
// Self-checking bench for balancing_state_feedback_controller_core: drives sensor requests,
// predicts both torques per control tick and checks every response in order.
// Depends on bsfc_pkg, bsfc_if and the controller RTL.
`timescale 1ns / 1ps

module tb;
  import bsfc_pkg::*;

  localparam int GAP_MAX     = 14;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 72;

  localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN = 32'h8000_0000;

  // Tracks the controller state and configuration and holds the torques still owed.
  class torque_scoreboard;
    localparam longint SPEED_LIMIT = 65536;
    localparam longint TURN_LIMIT  = 327680;
    localparam longint TORQUE_MAX  = 64'sd2147483647;
    localparam longint TORQUE_MIN  = -64'sd2147483648;

    logic               en, spd_mode, turn_mode;
    logic [31:0]        ref_disp, ref_hdg;
    logic [17:0]        ref_spd;
    logic [19:0]        ref_turn;
    logic signed [31:0] prev_pos, latched_pos, heading_acc;
    longint             gain_tab[2][6];
    out_item_t          expected_torques[$];
    int                 errors;

    function new();
      en          = 1'b1;
      spd_mode    = 1'b1;
      turn_mode   = 1'b1;
      ref_disp    = '0;
      ref_spd     = '0;
      ref_hdg     = '0;
      ref_turn    = '0;
      prev_pos    = '0;
      latched_pos = '0;
      heading_acc = '0;
      errors      = 0;
      gain_tab = '{'{-10, -10, 12, 1, -80, -10}, '{-10, -10, -12, -1, -80, -10}};
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] data);
      case (idx)
        CFG_ENABLE:      en        = data[0];
        CFG_SPEED_MODE:  spd_mode  = data[0];
        CFG_RATE_MODE:   turn_mode = data[0];
        CFG_REF_DISP:    ref_disp  = data;
        CFG_REF_SPEED:   ref_spd   = data[17:0];
        CFG_REF_HEADING: ref_hdg   = data;
        CFG_REF_TURN:    ref_turn  = data[19:0];
        default: ;
      endcase
    endfunction

    // Division rounding toward minus infinity, for a positive divisor.
    function longint floor_quot(longint v, longint d);
      if (v >= 0) return v / d;
      return -((-v + d - 1) / d);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void take_request(in_item_t it);
      longint    wl, wr, yaw, pitch, prate, pos, spd, inc, hd, acc, sum;
      longint    err[6];
      out_item_t want;
      wl    = longint'($signed(it.left_wheel_angle));
      wr    = longint'($signed(it.right_wheel_angle));
      yaw   = longint'($signed(it.yaw_rate));
      pitch = longint'($signed(it.pitch_angle));
      prate = longint'($signed(it.pitch_rate));

      if (it.latch_offset) latched_pos = prev_pos;
      if (it.clear_heading) heading_acc = '0;

      pos = floor_quot(wl + wr + 10, 20);
      spd = floor_quot((pos - longint'(prev_pos)) * 125 + 1, 2);
      prev_pos = pos[31:0];
      inc = floor_quot(yaw * 4 + 125, 250);
      sum = longint'(heading_acc) + inc;
      heading_acc = sum[31:0];
      hd = longint'(heading_acc);

      err[0] = longint'($signed(ref_disp)) - (spd_mode ? 0 : pos - longint'(latched_pos));
      err[1] = clamp(longint'($signed(ref_spd)), -SPEED_LIMIT, SPEED_LIMIT) - spd;
      err[2] = longint'($signed(ref_hdg)) - (turn_mode ? 0 : hd);
      err[3] = clamp(longint'($signed(ref_turn)), -TURN_LIMIT, TURN_LIMIT) - yaw;
      err[4] = -pitch;
      err[5] = -prate;

      for (int i = 0; i < 2; i++) begin
        acc = 0;
        for (int k = 0; k < 6; k++) acc += gain_tab[i][k] * err[k];
        acc = clamp(acc, TORQUE_MIN, TORQUE_MAX);
        if (!en) acc = 0;
        if (i == 0) want.left_torque = acc[31:0];
        else want.right_torque = acc[31:0];
      end
      expected_torques.push_back(want);
    endfunction

    function int pending();
      return expected_torques.size();
    endfunction

    task report(string msg);
      if (errors < 50) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_torques(out_item_t got);
      out_item_t want;
      if (expected_torques.size() == 0) begin
        report($sformatf("torque response with no request pending: %0d %0d",
                         got.left_torque, got.right_torque));
        return;
      end
      want = expected_torques.pop_front();
      if (got.left_torque !== want.left_torque)
        report($sformatf("left torque got %0d expected %0d", got.left_torque,
                         want.left_torque));
      if (got.right_torque !== want.right_torque)
        report($sformatf("right torque got %0d expected %0d", got.right_torque,
                         want.right_torque));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_wdata;

  bsfc_in_if  req_if ();
  bsfc_out_if rsp_if ();

  balancing_state_feedback_controller_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  torque_scoreboard sb = new();

  logic [31:0] wheel_l = '0;
  logic [31:0] wheel_r = '0;
  bit          spin_phase = 1'b0;
  bit          spin_neg = 1'b0;
  bit          req_burst = 1'b0;
  bit          rsp_burst = 1'b0;
  int          idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic in_item_t mk_item(logic [31:0] l, logic [31:0] r, logic [31:0] y,
                                       logic [31:0] p, logic [31:0] pr, bit lat, bit clr);
    in_item_t it;
    it.left_wheel_angle  = l;
    it.right_wheel_angle = r;
    it.yaw_rate          = y;
    it.pitch_angle       = p;
    it.pitch_rate        = pr;
    it.latch_offset      = lat;
    it.clear_heading     = clr;
    return it;
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 5))
      0: return W_MAX;
      1: return W_MIN;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'h1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] small_word(int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // Mostly a plausible balancing trajectory; the rest is extremes and raw noise.
  function automatic in_item_t gen_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      it = mk_item($urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, 1), $urandom_range(0, 1));
    end else if (pick < 35) begin
      it = mk_item(edge_word(), edge_word(), edge_word(), edge_word(), edge_word(),
                   $urandom_range(0, 1), $urandom_range(0, 1));
    end else begin
      wheel_l = wheel_l + small_word(4000);
      wheel_r = wheel_r + small_word(4000);
      it = mk_item(wheel_l, wheel_r, small_word(200000), small_word(20000),
                   small_word(60000), $urandom_range(0, 15) == 0,
                   $urandom_range(0, 15) == 0);
      // A steady spin drives the integrated heading across the signed wrap.
      if (spin_phase)
        it.yaw_rate = spin_neg ? W_MIN + 32'($urandom_range(0, 65535))
                               : 32'h7FFF_0000 + 32'($urandom_range(0, 65535));
    end
    if (spin_phase) it.clear_heading = 1'b0;
    return it;
  endfunction

  task automatic send_request(in_item_t it);
    int gap;
    gap = req_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= it;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    sb.take_request(it);
  endtask

  // Stops requests and waits for every owed torque pair to come back.
  task automatic drain_requests();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic randomize_config();
    logic [31:0] data;
    data = $urandom;
    data[0] = $urandom_range(0, 4) != 0;
    cfg_write(CFG_ENABLE, data);
    cfg_write(CFG_SPEED_MODE, $urandom);
    data = $urandom;
    if (spin_phase) data[0] = 1'b0;
    cfg_write(CFG_RATE_MODE, data);
    cfg_write(CFG_REF_DISP, $urandom_range(0, 1) ? edge_word() : small_word(300000));
    case ($urandom_range(0, 3))
      0: data = 32'd65536;
      1: data = 32'hFFFF_0000;
      2: data = $urandom;
      default: data = small_word(65536);
    endcase
    cfg_write(CFG_REF_SPEED, data);
    cfg_write(CFG_REF_HEADING, $urandom_range(0, 1) ? edge_word() : $urandom);
    case ($urandom_range(0, 3))
      0: data = 32'd327680;
      1: data = 32'hFFFB_0000;
      2: data = $urandom;
      default: data = small_word(327680);
    endcase
    cfg_write(CFG_REF_TURN, data);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_ENABLE;
    cfg_wdata      <= '0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: speed and rate modes, zero references.
    send_request(mk_item(0, 0, 0, 0, 0, 0, 0));
    send_request(mk_item(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 0, 0));
    send_request(mk_item(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 0, 0));
    send_request(mk_item(W_MAX, W_MIN, 1, 32'hFFFF_FFFF, 1, 1, 1));
    send_request(mk_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 1, 0));
    send_request(mk_item(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000,
                         32'hFFFF_8000, 0, 1));
    send_request(mk_item(W_MAX, W_MAX, 0, 0, 0, 0, 0));
    send_request(mk_item(W_MIN, W_MIN, 0, 0, 0, 0, 0));
    drain_requests();

    // Displacement and heading tracking, references beyond the speed and turn limits.
    cfg_write(CFG_SPEED_MODE, 32'd0);
    cfg_write(CFG_RATE_MODE, 32'd0);
    cfg_write(CFG_REF_DISP, W_MAX);
    cfg_write(CFG_REF_SPEED, 32'h0001_FFFF);
    cfg_write(CFG_REF_HEADING, W_MIN);
    cfg_write(CFG_REF_TURN, 32'h0007_FFFF);
    send_request(mk_item(W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, 1, 1));
    send_request(mk_item(W_MAX, W_MAX, W_MAX, 0, 0, 0, 0));
    send_request(mk_item(W_MAX, W_MAX, W_MAX, 0, 0, 0, 0));
    send_request(mk_item(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, 1, 0));
    send_request(mk_item(0, 0, W_MIN, 0, 0, 0, 1));
    drain_requests();

    cfg_write(CFG_REF_DISP, W_MIN);
    cfg_write(CFG_REF_SPEED, 32'h0002_0000);
    cfg_write(CFG_REF_HEADING, W_MAX);
    cfg_write(CFG_REF_TURN, 32'h0008_0000);
    send_request(mk_item(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, 0, 0));
    send_request(mk_item(W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, 1, 0));
    send_request(mk_item(0, 0, 0, 0, 0, 0, 1));
    drain_requests();

    // Disabled controller still advances its state.
    cfg_write(CFG_ENABLE, 32'd0);
    send_request(mk_item(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 0, 0));
    send_request(mk_item(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 1, 1));
    send_request(mk_item($urandom, $urandom, $urandom, $urandom, $urandom, 0, 0));
    drain_requests();

    for (int p = 0; p < PHASES; p++) begin
      spin_phase = (p % 3) == 1;
      spin_neg   = $urandom_range(0, 1);
      req_burst  = $urandom_range(0, 2) == 0;
      rsp_burst  = $urandom_range(0, 2) == 0;
      randomize_config();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) req_burst = !req_burst;
        send_request(gen_item());
      end
      drain_requests();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    int gap;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rsp_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
      sb.check_torques(rsp_if.payload);
    end
  end

  // Ends the run when no request, response or register write moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      idle_cycles = 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
